// ===== sv/assert_macros.svh =====
// Assertion macros used by the RTL sequencer (mlpsig_ctrl) of the perceptron inference block.
// Depends on nothing; the assertions vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// ===== sv/mlpsig_pkg.sv =====
// Package of the perceptron inference block: word types, codes, sizes and
// the sigmoid table. Depends on nothing.
package mlpsig_pkg;

  localparam int MAX_LAYERS      = 4;
  localparam int MAX_WIDTH       = 16;
  localparam int FRAC_BITS       = 12;
  localparam int SIGMOID_ENTRIES = 256;

  localparam logic [1:0] OP_WEIGHT   = 2'd0;
  localparam logic [1:0] OP_BIAS     = 2'd1;
  localparam logic [1:0] OP_ELEM     = 2'd2;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  localparam logic [2:0] REG_LAYER_COUNT = 3'd0;
  localparam logic [2:0] REG_SIZE0       = 3'd1;
  localparam logic [2:0] REG_SIZE3       = 3'd4;

  localparam logic [1:0] LAYER_SEL_BAD = 2'd3;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [1:0]         layer_sel;
    logic [3:0]         row_index;
    logic [3:0]         col_index;
    logic signed [15:0] data_value;
    logic               last_input;
  } mlp_in_t;

  typedef struct packed {
    logic [12:0] out_value;
    logic [3:0]  out_index;
    logic        out_last;
  } mlp_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       issue;
    logic       acc_clr;
    logic       bias_add;
    logic       act_wr;
    logic       out_ld;
    logic       src_sel;
    logic [9:0] w_addr;
    logic [5:0] b_addr;
    logic [3:0] rd_addr;
    logic [3:0] wr_addr;
    logic [3:0] out_index;
    logic       out_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  typedef logic [12:0] sig_tab_t [SIGMOID_ENTRIES];

  // Unsigned quotient by shift and subtract; both operands are non-negative.
  function automatic longint udiv_q(input longint num, input longint den);
    longint quo;
    longint rem;
    quo = 0;
    rem = 0;
    for (int b = 62; b >= 0; b--) begin
      rem = (rem <<< 1) | ((num >>> b) & longint'(1));
      quo = quo <<< 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | longint'(1);
      end
    end
    return quo;
  endfunction

  // Sigmoid at the midpoint of each table bin, built at elaboration in Q30.
  function automatic sig_tab_t build_sig_table();
    sig_tab_t tab;
    longint   m;
    longint   t;
    longint   u;
    longint   term;
    longint   sum;
    longint   num;
    longint   den;
    for (int k = 0; k < SIGMOID_ENTRIES; k++) begin
      m = (longint'(2 * k + 1) <<< (34 - ($clog2(SIGMOID_ENTRIES) + 1)))
          - (longint'(8) <<< 30);
      t = (m < 0) ? -m : m;
      u = t >>> 4;
      sum = longint'(1) <<< 30;
      term = longint'(1) <<< 30;
      for (int i = 1; i <= 12; i++) begin
        term = udiv_q((term * u) >>> 30, longint'(i));
        sum = i[0] ? sum - term : sum + term;
      end
      if (sum < 0) sum = 0;
      for (int i = 0; i < 4; i++) sum = (sum * sum) >>> 30;
      num = (m >= 0) ? (longint'(1) <<< 30) : sum;
      den = (longint'(1) <<< 30) + sum;
      tab[k] = 13'((udiv_q(num <<< (FRAC_BITS + 1), den) + 1) >>> 1);
    end
    return tab;
  endfunction

  localparam sig_tab_t SIG_TABLE = build_sig_table();

endpackage

// ===== sv/mlpsig_ctrl.sv =====
// Sequencer of the perceptron inference block: walks layers, rows and columns
// and then the output vector. Depends on mlpsig_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mlpsig_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [2:0]             layer_count_i,
  input  logic [3:0][4:0]        sizes_i,
  input  mlpsig_pkg::dp_status_t status_i,
  output mlpsig_pkg::ctrl_cmd_t  cmd_o,
  output logic                   busy_o
);
  import mlpsig_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MAC   = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_SUM   = 3'd3;
  localparam logic [2:0] S_ACT   = 3'd4;
  localparam logic [2:0] S_ORD   = 3'd5;
  localparam logic [2:0] S_OLD   = 3'd6;

  logic [2:0] state_q, state_d;
  logic [1:0] l_q, l_d;
  logic [3:0] r_q, r_d;
  logic [3:0] c_q, c_d;
  logic       dcnt_q, dcnt_d;
  logic [4:0] ncols, nrows;
  logic [1:0] l_next;
  logic       last_col, last_row;

  assign l_next   = l_q + 2'd1;
  assign ncols    = sizes_i[l_q];
  assign nrows    = sizes_i[l_next];
  assign last_col = ({1'b0, c_q} == ncols - 5'd1);
  // At output time the layer counter rests on the final layer.
  assign last_row = ({1'b0, r_q} == ((state_q == S_ORD || state_q == S_OLD) ?
                                     ncols : nrows) - 5'd1);

  always_comb begin
    state_d = state_q;
    l_d     = l_q;
    r_d     = r_q;
    c_d     = c_q;
    dcnt_d  = dcnt_q;
    cmd_o   = '0;
    cmd_o.src_sel   = l_q[0];
    cmd_o.w_addr    = {l_q, r_q, c_q};
    cmd_o.b_addr    = {l_q, r_q};
    cmd_o.rd_addr   = (state_q == S_MAC) ? c_q : r_q;
    cmd_o.wr_addr   = r_q;
    cmd_o.out_index = r_q;
    cmd_o.out_last  = last_row;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.acc_clr = 1'b1;
          l_d = '0;
          r_d = '0;
          c_d = '0;
          state_d = S_MAC;
        end
      end
      S_MAC: begin
        cmd_o.issue = 1'b1;
        if (last_col) begin
          dcnt_d  = 1'b0;
          state_d = S_DRAIN;
        end else begin
          c_d = c_q + 4'd1;
        end
      end
      S_DRAIN: begin
        dcnt_d = 1'b1;
        if (dcnt_q) state_d = S_SUM;
      end
      S_SUM: begin
        cmd_o.bias_add = 1'b1;
        state_d = S_ACT;
      end
      S_ACT: begin
        cmd_o.act_wr  = 1'b1;
        cmd_o.acc_clr = 1'b1;
        c_d = '0;
        if (last_row) begin
          r_d = '0;
          l_d = l_next;
          state_d = ({1'b0, l_next} == layer_count_i - 3'd1) ? S_ORD : S_MAC;
        end else begin
          r_d = r_q + 4'd1;
          state_d = S_MAC;
        end
      end
      S_ORD: begin
        state_d = S_OLD;
      end
      S_OLD: begin
        if (status_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          if (last_row) begin
            state_d = S_IDLE;
          end else begin
            r_d = r_q + 4'd1;
            state_d = S_ORD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      l_q     <= '0;
      r_q     <= '0;
      c_q     <= '0;
      dcnt_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      l_q     <= l_d;
      r_q     <= r_d;
      c_q     <= c_d;
      dcnt_q  <= dcnt_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  `ASSERT_CLK(a_start_enters_mac, clk_i, rst_ni,
              (state_q == S_IDLE && start_i) |=> (state_q == S_MAC && c_q == 4'd0))
  `ASSERT_NEVER(a_issue_col_range, clk_i, rst_ni, cmd_o.issue && ({1'b0, c_q} >= ncols))
  `ASSERT_NEVER(a_act_row_range, clk_i, rst_ni, cmd_o.act_wr && ({1'b0, r_q} >= nrows))
  `ASSERT_CLK(a_load_advances, clk_i, rst_ni,
              (cmd_o.out_ld && !cmd_o.out_last) |=> (state_q == S_ORD))

endmodule

// ===== sv/mlpsig_dp.sv =====
// Datapath of the perceptron inference block: weight, bias and activation
// memories, the multiply-accumulate pipe, sigmoid and output register.
// Depends on mlpsig_pkg.
module mlpsig_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_take_i,
  input  mlpsig_pkg::mlp_in_t    in_word_i,
  input  mlpsig_pkg::ctrl_cmd_t  cmd_i,
  output mlpsig_pkg::dp_status_t status_o,
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output mlpsig_pkg::mlp_out_t   out_word_o
);
  import mlpsig_pkg::*;

  logic signed [15:0] w_mem [768];
  logic signed [15:0] b_mem [48];
  logic [15:0]        act_a [MAX_WIDTH];
  logic [15:0]        act_b [MAX_WIDTH];

  logic signed [15:0] w_rd_q, b_rd_q;
  logic [15:0]        a_rd_q, b_act_rd_q;
  logic               v1_q, v2_q;
  logic signed [31:0] prod_q;
  logic signed [39:0] acc_q, acc_d;
  logic               out_valid_q;
  mlp_out_t           out_q;

  logic signed [15:0] src_val;
  logic signed [40:0] sum_ext, addend;
  logic signed [27:0] z;
  logic [12:0]        act_val;
  logic [7:0]         tab_idx;

  // Host writes land only while the block is idle.
  always_ff @(posedge clk_i) begin
    if (in_take_i && in_word_i.layer_sel != LAYER_SEL_BAD) begin
      if (in_word_i.opcode == OP_WEIGHT)
        w_mem[{in_word_i.layer_sel, in_word_i.row_index, in_word_i.col_index}]
          <= in_word_i.data_value;
      if (in_word_i.opcode == OP_BIAS)
        b_mem[{in_word_i.layer_sel, in_word_i.row_index}] <= in_word_i.data_value;
    end
    w_rd_q <= w_mem[cmd_i.w_addr];
    b_rd_q <= b_mem[cmd_i.b_addr];
  end

  always_ff @(posedge clk_i) begin
    if (in_take_i && in_word_i.opcode == OP_ELEM)
      act_a[in_word_i.col_index] <= in_word_i.data_value;
    else if (cmd_i.act_wr && cmd_i.src_sel)
      act_a[cmd_i.wr_addr] <= {3'b000, act_val};
    if (cmd_i.act_wr && !cmd_i.src_sel)
      act_b[cmd_i.wr_addr] <= {3'b000, act_val};
    a_rd_q     <= act_a[cmd_i.rd_addr];
    b_act_rd_q <= act_b[cmd_i.rd_addr];
  end

  assign src_val = cmd_i.src_sel ? b_act_rd_q : a_rd_q;

  always_ff @(posedge clk_i) begin
    prod_q <= w_rd_q * src_val;
  end

  // The bias enters as bias * 2^12 with the same saturation as the products.
  assign addend  = cmd_i.bias_add ? 41'(signed'({b_rd_q, 12'h000})) : 41'(prod_q);
  assign sum_ext = 41'(acc_q) + addend;

  always_comb begin
    if (sum_ext[40] != sum_ext[39])
      acc_d = sum_ext[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
    else
      acc_d = sum_ext[39:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      acc_q <= '0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      if (cmd_i.acc_clr)
        acc_q <= '0;
      else if (v2_q || cmd_i.bias_add)
        acc_q <= acc_d;
    end
  end

  // Arithmetic shift floors; the table covers z in [-8, 8).
  assign z       = acc_q[39:12];
  assign tab_idx = {~z[15], z[14:8]};

  always_comb begin
    if (z[27:15] == '0 || z[27:15] == '1)
      act_val = SIG_TABLE[tab_idx];
    else if (z[27])
      act_val = '0;
    else
      act_val = 13'd4096;
  end

  assign status_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_q.out_value <= src_val[12:0];
      out_q.out_index <= cmd_i.out_index;
      out_q.out_last  <= cmd_i.out_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ===== sv/mlp_sigmoid_inference.sv =====
// Top level of the fully connected perceptron inference block with sigmoid
// activations. Depends on mlpsig_pkg, mlpsig_ctrl and mlpsig_dp.
//
// Usage: the input channel takes words that write one weight, one bias or
// one input element. Every word is taken in the cycle it is offered while
// the block is idle. An input element flagged last_input starts a pass,
// during which in_stall_o stays high. Each neuron row is worked by the
// single shared multiply-accumulate pipe: one column per cycle, then the
// pipe drain, the bias add, and the sigmoid and write-back. After the final
// layer the output vector is sent one word per neuron, each through a
// registered activation read and then a load of the output register.
// When the receiver stalls, the output register holds its word and the
// sequencer waits. Reset clears the control state, the accumulator and the
// configuration registers (two layers of 16); the memories are undefined
// until written. Configuration writes are taken whenever cfg_we_i is high
// and must only be issued while the block is idle.
module mlp_sigmoid_inference (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  mlpsig_pkg::mlp_in_t  in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output mlpsig_pkg::mlp_out_t out_word_o,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_index_i,
  input  logic [4:0]           cfg_data_i
);
  import mlpsig_pkg::*;

  logic [2:0]      layer_count_q;
  logic [3:0][4:0] size_q;
  logic [2:0]      lc_clamped;
  logic [3:0][4:0] size_clamped;
  logic            busy;
  logic            in_take;
  logic            start;
  ctrl_cmd_t       cmd;
  dp_status_t      status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_count_q <= 3'd2;
      size_q        <= {4{5'd16}};
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_LAYER_COUNT)
        layer_count_q <= cfg_data_i[2:0];
      else if (cfg_index_i >= REG_SIZE0 && cfg_index_i <= REG_SIZE3)
        size_q[2'(cfg_index_i - REG_SIZE0)] <= cfg_data_i;
    end
  end

  always_comb begin
    if (layer_count_q < 3'd2)
      lc_clamped = 3'd2;
    else if (layer_count_q > 3'(MAX_LAYERS))
      lc_clamped = 3'(MAX_LAYERS);
    else
      lc_clamped = layer_count_q;
    for (int i = 0; i < 4; i++) begin
      if (size_q[i] == 5'd0)
        size_clamped[i] = 5'd1;
      else if (size_q[i] > 5'(MAX_WIDTH))
        size_clamped[i] = 5'(MAX_WIDTH);
      else
        size_clamped[i] = size_q[i];
    end
  end

  assign in_stall_o = busy;
  assign in_take    = in_valid_i && !busy;
  assign start      = in_take && in_word_i.opcode == OP_ELEM && in_word_i.last_input;

  mlpsig_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .layer_count_i (lc_clamped),
    .sizes_i       (size_clamped),
    .status_i      (status),
    .cmd_o         (cmd),
    .busy_o        (busy)
  );

  mlpsig_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_take_i   (in_take),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for mlp_sigmoid_inference: directed words, then random passes.
// Depends on mlpsig_pkg for the word types and codes; carries its own network predictor.
`timescale 1ns / 1ps

module tb;
  import mlpsig_pkg::*;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  mlp_in_t  in_word = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  mlp_out_t out_word;
  logic     cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [4:0] cfg_data = '0;

  mlp_sigmoid_inference i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_word_i(in_word),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_word_o(out_word),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: memories, the two activation banks and the registers.
  logic signed [15:0] wmem [768];
  logic signed [15:0] bmem [48];
  logic signed [15:0] act [2][16];
  bit          w_ok [768];
  bit          b_ok [48];
  bit          a_ok [16];
  logic [2:0]  lc_reg;
  logic [4:0]  size_reg [4];
  logic [12:0] sig_lut [256];
  mlp_out_t    outputs_due [$];
  int          errors = 0;
  int          words_sent = 0;
  bit          quiet = 1'b0;

  typedef struct {
    mlp_in_t     w;
    bit          typed;
    logic [12:0] value;
  } dir_row_t;

  task automatic report(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void build_lut();
    longint m, t, u, term, sum, num, den;
    for (int k = 0; k < 256; k++) begin
      m = (longint'(2 * k + 1) <<< 34) / 512 - (longint'(8) <<< 30);
      t = (m < 0) ? -m : m;
      u = t >>> 4;
      sum = longint'(1) <<< 30;
      term = sum;
      for (int i = 1; i <= 12; i++) begin
        term = ((term * u) >>> 30) / i;
        if (i % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
      if (sum < 0) sum = 0;
      for (int i = 0; i < 4; i++) sum = (sum * sum) >>> 30;
      num = (m >= 0) ? (longint'(1) <<< 30) : sum;
      den = (longint'(1) <<< 30) + sum;
      sig_lut[k] = 13'((((num <<< 13) / den) + 1) >>> 1);
    end
  endfunction

  function automatic longint sat40(input longint v);
    if (v > (longint'(1) <<< 39) - 1) return (longint'(1) <<< 39) - 1;
    if (v < -(longint'(1) <<< 39)) return -(longint'(1) <<< 39);
    return v;
  endfunction

  function automatic logic [12:0] sigmoid_of(input longint acc);
    longint z;
    z = acc >>> 12;  // arithmetic shift rounds toward minus infinity
    if (z < -32768) return 13'd0;
    if (z >= 32768) return 13'd4096;
    return sig_lut[((z + 32768) * 256) >>> 16];
  endfunction

  function automatic int eff_size(input int l);
    if (size_reg[l] == 0) return 1;
    if (size_reg[l] > 16) return 16;
    return size_reg[l];
  endfunction

  function automatic int eff_layers();
    if (lc_reg < 2) return 2;
    if (lc_reg > 4) return 4;
    return lc_reg;
  endfunction

  function automatic void forward_pass();
    int src, n, lc;
    longint acc;
    mlp_out_t o;
    src = 0;
    lc = eff_layers();
    for (int l = 0; l < lc - 1; l++) begin
      for (int r = 0; r < eff_size(l + 1); r++) begin
        acc = 0;
        for (int c = 0; c < eff_size(l); c++)
          acc = sat40(acc + longint'(wmem[(l * 16 + r) * 16 + c]) * longint'(act[src][c]));
        acc = sat40(acc + longint'(bmem[l * 16 + r]) * 4096);
        act[1 - src][r] = {3'b000, sigmoid_of(acc)};
      end
      src = 1 - src;
    end
    n = eff_size(lc - 1);
    for (int r = 0; r < n; r++) begin
      o.out_value = act[src][r][12:0];
      o.out_index = 4'(r);
      o.out_last  = (r == n - 1);
      outputs_due.push_back(o);
    end
  endfunction

  function automatic void predict(input mlp_in_t w);
    case (w.opcode)
      OP_WEIGHT: begin
        if (w.layer_sel != LAYER_SEL_BAD) begin
          wmem[(w.layer_sel * 16 + w.row_index) * 16 + w.col_index] = w.data_value;
          w_ok[(w.layer_sel * 16 + w.row_index) * 16 + w.col_index] = 1'b1;
        end
      end
      OP_BIAS: begin
        if (w.layer_sel != LAYER_SEL_BAD) begin
          bmem[w.layer_sel * 16 + w.row_index] = w.data_value;
          b_ok[w.layer_sel * 16 + w.row_index] = 1'b1;
        end
      end
      OP_ELEM: begin
        act[0][w.col_index] = w.data_value;
        a_ok[w.col_index] = 1'b1;
        if (w.last_input) forward_pass();
      end
      default: ;
    endcase
  endfunction

  task automatic send_word(input mlp_in_t w);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk_i); while (in_stall);
    predict(w);
    if (!(w.opcode == OP_RESERVED || (w.opcode != OP_ELEM && w.layer_sel == LAYER_SEL_BAD)))
      words_sent++;
  endtask

  // All five registers go out back to back so the write enable drops only once.
  task automatic apply_cfg(input logic [2:0] lc, input logic [4:0] s0, input logic [4:0] s1,
                           input logic [4:0] s2, input logic [4:0] s3);
    logic [4:0] vals [5];
    vals = '{5'(lc), s0, s1, s2, s3};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_LAYER_COUNT + 3'(i);
      cfg_data  <= vals[i];
      @(posedge clk_i);
      if (i == 0) lc_reg = lc;
      else size_reg[i - 1] = vals[i];
    end
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (outputs_due.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  function automatic mlp_in_t make_word(input logic [1:0] op, input logic [1:0] ls,
                                        input int r, input int c, input logic [15:0] d,
                                        input bit last);
    mlp_in_t w;
    w.opcode = op; w.layer_sel = ls; w.row_index = 4'(r); w.col_index = 4'(c);
    w.data_value = d; w.last_input = last;
    return w;
  endfunction

  function automatic logic [15:0] rnd_data();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      default: return 16'($urandom_range(0, 6143)) - 16'd3072;
    endcase
  endfunction

  function automatic logic [4:0] rnd_size();
    case ($urandom_range(0, 11))
      0: return 5'd16;
      1: return 5'($urandom);
      default: return 5'($urandom_range(1, 4));
    endcase
  endfunction

  task automatic random_pass();
    int lc, n, k;
    quiet = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 2) == 0) begin
      if ($urandom_range(0, 4) == 0) lc = $urandom_range(0, 7);
      else lc = $urandom_range(2, 4);
      apply_cfg(3'(lc), rnd_size(), rnd_size(), rnd_size(), rnd_size());
    end
    lc = eff_layers();
    n = $urandom_range(0, 2);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 1) == 0)
        send_word(make_word(OP_RESERVED, 2'($urandom), $urandom, $urandom, 16'($urandom),
                            1'($urandom)));
      else
        send_word(make_word(2'($urandom_range(0, 1)), LAYER_SEL_BAD, $urandom, $urandom,
                            16'($urandom), 1'($urandom)));
    end
    // Overwrite some live coefficients, then fill whatever the pass will read.
    n = $urandom_range(0, 6);
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, lc - 2);
      send_word(make_word($urandom_range(0, 1) ? OP_BIAS : OP_WEIGHT, 2'(k),
                          $urandom_range(0, eff_size(k + 1) - 1),
                          $urandom_range(0, eff_size(k) - 1), rnd_data(), 1'($urandom)));
    end
    for (int l = 0; l < lc - 1; l++)
      for (int r = 0; r < eff_size(l + 1); r++) begin
        for (int c = 0; c < eff_size(l); c++)
          if (!w_ok[(l * 16 + r) * 16 + c])
            send_word(make_word(OP_WEIGHT, 2'(l), r, c, rnd_data(), 1'($urandom)));
        if (!b_ok[l * 16 + r])
          send_word(make_word(OP_BIAS, 2'(l), r, $urandom, rnd_data(), 1'($urandom)));
      end
    k = $urandom_range(0, 15);
    for (int c = 0; c < eff_size(0); c++)
      if (c != k && (!a_ok[c] || $urandom_range(0, 1) == 0))
        send_word(make_word(OP_ELEM, 2'($urandom), $urandom, c, rnd_data(), 1'b0));
    send_word(make_word(OP_ELEM, 2'($urandom), $urandom, k, rnd_data(), 1'b1));
    wait_idle();
  endtask

  // Output side: stall a random number of cycles before each word.
  initial begin
    int n;
    mlp_out_t e;
    forever begin
      n = quiet ? 0 : $urandom_range(0, 9);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!(out_valid === 1'b1) || !rst_ni);
      if (outputs_due.size() == 0) begin
        report($sformatf("unexpected word value %0d index %0d last %0d",
                         out_word.out_value, out_word.out_index, out_word.out_last));
      end else begin
        e = outputs_due.pop_front();
        if (out_word.out_value !== e.out_value || out_word.out_index !== e.out_index ||
            out_word.out_last !== e.out_last)
          report($sformatf("got value %0d index %0d last %0d, want %0d %0d %0d",
                           out_word.out_value, out_word.out_index, out_word.out_last,
                           e.out_value, e.out_index, e.out_last));
      end
    end
  end

  initial begin
    #20000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    dir_row_t rows [$];
    build_lut();
    lc_reg = 3'd2;
    for (int i = 0; i < 4; i++) size_reg[i] = 5'd16;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single-neuron network so saturated outcomes can be read off directly.
    apply_cfg(3'd2, 5'd1, 5'd1, 5'd16, 5'd16);
    rows = '{
      '{make_word(OP_WEIGHT, 2'd0, 0, 0, 16'h7FFF, 1'b0), 1'b0, 13'd0},
      '{make_word(OP_BIAS, 2'd0, 0, 0, 16'h7FFF, 1'b0), 1'b0, 13'd0},
      '{make_word(OP_ELEM, 2'd0, 0, 0, 16'h7FFF, 1'b1), 1'b1, 13'd4096},
      '{make_word(OP_RESERVED, 2'd0, 0, 0, 16'h1234, 1'b1), 1'b0, 13'd0},
      '{make_word(OP_BIAS, LAYER_SEL_BAD, 0, 0, 16'h4000, 1'b0), 1'b0, 13'd0},
      '{make_word(OP_WEIGHT, LAYER_SEL_BAD, 15, 15, 16'h8000, 1'b1), 1'b0, 13'd0},
      '{make_word(OP_BIAS, 2'd0, 0, 15, 16'h8000, 1'b0), 1'b0, 13'd0},
      '{make_word(OP_ELEM, 2'd3, 15, 0, 16'h8000, 1'b1), 1'b1, 13'd0},
      '{make_word(OP_WEIGHT, 2'd0, 0, 0, 16'h0000, 1'b0), 1'b0, 13'd0},
      '{make_word(OP_BIAS, 2'd0, 0, 0, 16'h0000, 1'b0), 1'b0, 13'd0},
      '{make_word(OP_ELEM, 2'd0, 0, 0, 16'h0000, 1'b1), 1'b0, 13'd0},
      '{make_word(OP_WEIGHT, 2'd2, 15, 15, 16'h8000, 1'b0), 1'b0, 13'd0},
      '{make_word(OP_BIAS, 2'd2, 15, 0, 16'hFFFF, 1'b0), 1'b0, 13'd0},
      '{make_word(OP_ELEM, 2'd0, 0, 5, 16'h0FFF, 1'b0), 1'b0, 13'd0},
      '{make_word(OP_ELEM, 2'd0, 0, 15, 16'hF000, 1'b1), 1'b0, 13'd0},
      '{make_word(OP_WEIGHT, 2'd0, 0, 0, 16'h1000, 1'b0), 1'b0, 13'd0},
      '{make_word(OP_ELEM, 2'd1, 0, 0, 16'h0800, 1'b1), 1'b0, 13'd0}
    };
    foreach (rows[i]) begin
      send_word(rows[i].w);
      if (rows[i].typed) outputs_due[$].out_value = rows[i].value;
    end
    wait_idle();

    // Deepest network at full width, then the random passes.
    apply_cfg(3'd4, 5'd16, 5'd16, 5'd16, 5'd16);
    random_pass();
    while (words_sent < 460) random_pass();
    apply_cfg(3'd7, 5'd0, 5'd31, 5'd1, 5'd16);
    random_pass();

    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
